// ===== rtl/smx_pkg.sv =====
// Shared types and constants for the stack machine execute block.
package smx_pkg;

    // Word and field widths of the instruction format, and the error code width.
    localparam int WORD_W = 32;
    localparam int IMM_W  = 30;
    localparam int KIND_W = 2;
    localparam int ERR_W  = 3;

    localparam logic [IMM_W-1:0] IMM_MASK = 30'h3fff_ffff;

    // Instruction type field.
    localparam logic [KIND_W-1:0] KIND_POS  = 2'b00;
    localparam logic [KIND_W-1:0] KIND_PRIM = 2'b01;
    localparam logic [KIND_W-1:0] KIND_NEG  = 2'b10;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'b11;

    // Primitive selectors.
    localparam logic [IMM_W-1:0] PRIM_HALT = 30'd0;
    localparam logic [IMM_W-1:0] PRIM_ADD  = 30'd1;
    localparam logic [IMM_W-1:0] PRIM_SUB  = 30'd2;
    localparam logic [IMM_W-1:0] PRIM_MUL  = 30'd3;
    localparam logic [IMM_W-1:0] PRIM_DIV  = 30'd4;

    // Error codes reported with each result item.
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [ERR_W-1:0] ERR_DIVZERO   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BADTYPE   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd5;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_DIV,
        ST_DIVEND,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/stack_machine_execute_top.sv =====
// Stack machine execute unit: stack memory, sequencer and iterative divider.
//
//  Channel | Direction | Ports                                           | Moves
//  s_      | in        | s_valid, s_ready, s_instruction_word            | one instruction item
//  m_      | out       | m_valid, m_ready, m_top_value, m_stack_empty,   | one result item
//          |           | m_stopped, m_error_code                         |
//
// Push, halt, errors and ignored items pass through the decode and output states;
// add, sub and mul also pass through execute for the registered second-entry read.
// Divide then runs a restoring divider that retires one quotient bit per cycle.
// aresetn is synchronous and active low; it clears the stack count and the stop flag,
// and the stack memory needs no clearing pass since only written entries are read.
// A new item is taken as soon as the previous result sits in the output register;
// a stalled m_ready holds the block only once a further result is ready to leave.
module stack_machine_execute_top #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [smx_pkg::WORD_W-1:0]        s_instruction_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [smx_pkg::WORD_W-1:0] m_top_value,
    output logic                              m_stack_empty,
    output logic                              m_stopped,
    output logic [smx_pkg::ERR_W-1:0]         m_error_code
);
    import smx_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W = $clog2(WORD_W);

    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(WORD_W - 1);

    // Stack memory with registered read data.
    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Sequencer and architectural state.
    state_t            state_reg, state_next;
    logic [WORD_W-1:0] instr_reg, instr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] top_reg, top_next;
    logic              stopped_reg, stopped_next;
    logic [ERR_W-1:0]  err_reg, err_next;

    // Divider registers.
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_top_value_reg, m_top_value_next;
    logic              m_stack_empty_reg, m_stack_empty_next;
    logic              m_stopped_reg, m_stopped_next;
    logic [ERR_W-1:0]  m_error_code_reg, m_error_code_next;

    // Decoded fields and datapath values.
    logic [KIND_W-1:0] kind;
    logic [IMM_W-1:0]  imm;
    logic [WORD_W-1:0] push_val;
    logic [WORD_W-1:0] opa, opb;
    logic [WORD_W-1:0] abs_a, abs_b;
    logic [WORD_W-1:0] prod;
    logic [WORD_W:0]   rem_sh, rem_diff;
    logic [WORD_W-1:0] quo_final;
    logic [CNT_W-1:0]  count_m2;
    logic              out_free;
    logic              s_accept;

    // Stack memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    // Field decode and arithmetic.
    assign kind      = instr_reg[WORD_W-1 -: KIND_W];
    assign imm       = instr_reg[IMM_W-1:0] & IMM_MASK;
    assign push_val  = (kind == KIND_NEG) ? (WORD_W'(0) - {{(WORD_W-IMM_W){1'b0}}, imm})
                                          : {{(WORD_W-IMM_W){1'b0}}, imm};
    assign opa       = rd_data_reg;
    assign opb       = top_reg;
    assign abs_a     = opa[WORD_W-1] ? (WORD_W'(0) - opa) : opa;
    assign abs_b     = opb[WORD_W-1] ? (WORD_W'(0) - opb) : opb;
    assign prod      = opa * opb;
    assign rem_sh    = {rem_reg, quo_reg[WORD_W-1]};
    assign rem_diff  = rem_sh - {1'b0, den_reg};
    assign quo_final = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
    assign count_m2  = count_reg - CNT_TWO;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && out_free);
    assign s_accept = s_valid && s_ready;

    // State and data registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        instr_reg         <= instr_next;
        top_reg           <= top_next;
        rem_reg           <= rem_next;
        quo_reg           <= quo_next;
        den_reg           <= den_next;
        neg_reg           <= neg_next;
        iter_reg          <= iter_next;
        m_top_value_reg   <= m_top_value_next;
        m_stack_empty_reg <= m_stack_empty_next;
        m_stopped_reg     <= m_stopped_next;
        m_error_code_reg  <= m_error_code_next;
    end

    // Next state and datapath control. Reads happen only in decode, where only a push
    // writes and then no read is made, so a read never meets a write in one cycle.
    always_comb begin
        state_next         = state_reg;
        instr_next         = instr_reg;
        count_next         = count_reg;
        top_next           = top_reg;
        stopped_next       = stopped_reg;
        err_next           = err_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        den_next           = den_reg;
        neg_next           = neg_reg;
        iter_next          = iter_reg;
        m_valid_next       = m_valid_reg;
        m_top_value_next   = m_top_value_reg;
        m_stack_empty_next = m_stack_empty_reg;
        m_stopped_next     = m_stopped_reg;
        m_error_code_next  = m_error_code_reg;
        mem_we             = 1'b0;
        mem_waddr          = count_reg[ADDR_W-1:0];
        mem_wdata          = push_val;
        mem_re             = 1'b0;
        mem_raddr          = count_m2[ADDR_W-1:0];

        // The output slot empties when the current result item is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    instr_next = s_instruction_word;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                err_next   = ERR_NONE;
                state_next = ST_OUT;
                if (!stopped_reg) begin
                    if (kind inside {KIND_POS, KIND_NEG}) begin
                        if (count_reg == CNT_FULL) begin
                            err_next     = ERR_OVERFLOW;
                            stopped_next = 1'b1;
                        end else begin
                            mem_we     = 1'b1;
                            top_next   = push_val;
                            count_next = count_reg + CNT_ONE;
                        end
                    end else if (kind == KIND_BAD) begin
                        err_next     = ERR_BADTYPE;
                        stopped_next = 1'b1;
                    end else if (imm == PRIM_HALT) begin
                        stopped_next = 1'b1;
                    end else if (imm > PRIM_DIV) begin
                        err_next     = ERR_UNKNOWN;
                        stopped_next = 1'b1;
                    end else if (count_reg < CNT_TWO) begin
                        err_next     = ERR_UNDERFLOW;
                        stopped_next = 1'b1;
                    end else if ((imm == PRIM_DIV) && (top_reg == '0)) begin
                        err_next     = ERR_DIVZERO;
                        stopped_next = 1'b1;
                    end else begin
                        // Fetch the entry under the top; the top itself is cached.
                        mem_re     = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                mem_waddr = count_m2[ADDR_W-1:0];
                if (imm == PRIM_DIV) begin
                    rem_next   = '0;
                    quo_next   = abs_a;
                    den_next   = abs_b;
                    neg_next   = opa[WORD_W-1] ^ opb[WORD_W-1];
                    iter_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    case (imm)
                        PRIM_ADD: mem_wdata = opa + opb;
                        PRIM_SUB: mem_wdata = opa - opb;
                        default:  mem_wdata = prod;
                    endcase
                    mem_we     = 1'b1;
                    top_next   = mem_wdata;
                    count_next = count_reg - CNT_ONE;
                    state_next = ST_OUT;
                end
            end

            // One restoring step per cycle on the magnitudes.
            ST_DIV: begin
                if (!rem_diff[WORD_W]) begin
                    rem_next = rem_diff[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_DIVEND;
                end
            end

            ST_DIVEND: begin
                mem_we     = 1'b1;
                mem_waddr  = count_m2[ADDR_W-1:0];
                mem_wdata  = quo_final;
                top_next   = quo_final;
                count_next = count_reg - CNT_ONE;
                state_next = ST_OUT;
            end

            // Hand the result to the output register once it is free, and take the next item if offered.
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_top_value_next   = (count_reg == '0) ? '0 : top_reg;
                    m_stack_empty_next = (count_reg == '0);
                    m_stopped_next     = stopped_reg;
                    m_error_code_next  = err_reg;
                    if (s_accept) begin
                        instr_next = s_instruction_word;
                        state_next = ST_DECODE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_top_value   = m_top_value_reg;
    assign m_stack_empty = m_stack_empty_reg;
    assign m_stopped     = m_stopped_reg;
    assign m_error_code  = m_error_code_reg;

    // The stack never holds more entries than the memory has.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("stack count exceeds depth");

    // Once stopped, the block stays stopped until reset.
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    // An item seen while stopped leaves the stack alone.
    a_stopped_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECODE && stopped_reg) |=> $stable(count_reg) && $stable(top_reg))
        else $error("stack changed while stopped");

    // An accepted item always starts at decode.
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_DECODE)
        else $error("accepted item not decoded");

    // An empty stack reports a zero top value.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stack_empty_reg) |-> m_top_value_reg == '0)
        else $error("empty stack with non-zero top value");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the stack machine execute block, with a mirrored stack model.
module tb;
    import smx_pkg::*;

    localparam int STACK_DEPTH  = 1024;
    localparam int RANDOM_ITEMS = 1850;
    localparam int NOISE_ITEMS  = 24;
    localparam int SETTLE_ITEMS = 60;

    // Two copies of the machine state: one steers stimulus, one mirrors the block.
    localparam int PLAN   = 0;
    localparam int MIRROR = 1;

    typedef struct packed {
        logic [WORD_W-1:0] top;
        logic              empty;
        logic              stopped;
        logic [ERR_W-1:0]  err;
    } machine_result_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              drain_first;
    } instr_item_t;

    // Ways in which the run brings the machine to a stop.
    typedef enum int {
        FIN_HALT,
        FIN_UNDERFLOW,
        FIN_DIVZERO,
        FIN_UNKNOWN,
        FIN_BADTYPE,
        FIN_OVERFLOW
    } finale_t;

    logic                       aclk;
    logic                       aresetn            = 1'b0;
    logic                       s_valid            = 1'b0;
    logic                       s_ready;
    logic [WORD_W-1:0]          s_instruction_word = '0;
    logic                       m_valid;
    logic                       m_ready            = 1'b0;
    logic signed [WORD_W-1:0]   m_top_value;
    logic                       m_stack_empty;
    logic                       m_stopped;
    logic [ERR_W-1:0]           m_error_code;

    logic [WORD_W-1:0] shadow_mem [2][STACK_DEPTH];
    int                shadow_depth [2];
    bit                shadow_stopped [2];

    instr_item_t     instr_q[$];
    machine_result_t awaited_results[$];

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   send_wait  = 0;
    int   send_quiet = 0;
    int   recv_wait  = 0;
    int   recv_quiet = 0;
    int   failures   = 0;
    int   results_seen = 0;

    stack_machine_execute_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_instruction_word(s_instruction_word),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_top_value       (m_top_value),
        .m_stack_empty     (m_stack_empty),
        .m_stopped         (m_stopped),
        .m_error_code      (m_error_code)
    );

    // Clock with a period of ten time units.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void machine_clear(int who);
        shadow_depth[who]   = 0;
        shadow_stopped[who] = 1'b0;
    endfunction

    // Executes one instruction on the chosen copy of the machine and returns its result item.
    function automatic machine_result_t machine_step(int who, logic [WORD_W-1:0] word);
        logic [KIND_W-1:0] kind;
        logic [IMM_W-1:0]  data;
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
        logic [WORD_W-1:0] mag_l;
        logic [WORD_W-1:0] mag_r;
        logic [WORD_W-1:0] value;
        logic [ERR_W-1:0]  err;
        machine_result_t   res;
        kind  = word[WORD_W-1 -: KIND_W];
        data  = word[IMM_W-1:0];
        err   = ERR_NONE;
        value = '0;
        if (!shadow_stopped[who]) begin
            if (kind == KIND_POS || kind == KIND_NEG) begin
                if (shadow_depth[who] >= STACK_DEPTH) begin
                    err = ERR_OVERFLOW;
                end else begin
                    value = {{(WORD_W-IMM_W){1'b0}}, data};
                    shadow_mem[who][shadow_depth[who]] = (kind == KIND_NEG) ? -value : value;
                    shadow_depth[who]++;
                end
            end else if (kind == KIND_BAD) begin
                err = ERR_BADTYPE;
            end else if (data == PRIM_HALT) begin
                shadow_stopped[who] = 1'b1;
            end else if (data > PRIM_DIV) begin
                err = ERR_UNKNOWN;
            end else if (shadow_depth[who] < 2) begin
                err = ERR_UNDERFLOW;
            end else begin
                rhs = shadow_mem[who][shadow_depth[who]-1];
                lhs = shadow_mem[who][shadow_depth[who]-2];
                case (data)
                    PRIM_ADD: value = lhs + rhs;
                    PRIM_SUB: value = lhs - rhs;
                    PRIM_MUL: value = lhs * rhs;
                    default: begin
                        // Divide the magnitudes and then restore the sign, so the quotient
                        // truncates towards zero and the most negative value over minus one
                        // wraps back to itself.
                        mag_l = lhs[WORD_W-1] ? -lhs : lhs;
                        mag_r = rhs[WORD_W-1] ? -rhs : rhs;
                        if (rhs == '0) begin
                            err = ERR_DIVZERO;
                        end else begin
                            value = mag_l / mag_r;
                            if (lhs[WORD_W-1] != rhs[WORD_W-1]) value = -value;
                        end
                    end
                endcase
                if (err == ERR_NONE) begin
                    shadow_depth[who]--;
                    shadow_mem[who][shadow_depth[who]-1] = value;
                end
            end
            if (err != ERR_NONE) shadow_stopped[who] = 1'b1;
        end
        res.empty = (shadow_depth[who] == 0);
        if (res.empty) begin
            res.top = '0;
        end else begin
            res.top = shadow_mem[who][shadow_depth[who]-1];
        end
        res.stopped = shadow_stopped[who];
        res.err     = err;
        return res;
    endfunction

    // Queues an instruction and advances the planning copy so later choices see its effect.
    task automatic queue_instr(logic [WORD_W-1:0] word, logic drain_first);
        instr_item_t     entry;
        void'(machine_step(PLAN, word));
        entry.word        = word;
        entry.drain_first = drain_first;
        instr_q.insert(instr_q.size(), entry);
    endtask

    function automatic logic [IMM_W-1:0] pick_imm();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return IMM_MASK;
            2:       return IMM_W'($urandom_range(1, 16));
            default: return IMM_W'($urandom);
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_push_kind();
        return ($urandom_range(0, 1) == 1) ? KIND_NEG : KIND_POS;
    endfunction

    // Wait before the next item: mostly random, with occasional runs of back-to-back items.
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    task automatic check_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: result %0d %s expected 0x%0h, actual 0x%0h",
                     $time, results_seen, field, want, got);
        end
    endtask

    // Instruction driver: holds each item until accepted, then waits its drawn gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait = 0;
        end else if (!s_valid || in_taken) begin
            if (in_taken) send_wait = draw_wait(send_quiet);
            if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (instr_q.size() != 0 &&
                         (!instr_q[0].drain_first || awaited_results.size() == 0)) begin
                s_instruction_word <= instr_q[0].word;
                s_valid            <= 1'b1;
                void'(instr_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: drops ready for a drawn number of cycles after each item.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait = 0;
        end else if (out_taken) begin
            recv_wait = draw_wait(recv_quiet);
            m_ready <= (recv_wait == 0);
        end else if (!m_ready) begin
            if (recv_wait > 0) recv_wait--;
            m_ready <= (recv_wait == 0);
        end
    end

    // Monitor: checks each result item, then predicts the result of each accepted instruction.
    always @(posedge aclk) begin
        machine_result_t want;
        machine_result_t pred;
        if (!aresetn) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
            machine_clear(MIRROR);
        end else begin
            in_taken  <= s_valid && s_ready;
            out_taken <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, expected none, actual top_value 0x%0h",
                             $time, m_top_value);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("top_value", want.top, m_top_value);
                    check_field("stack_empty", WORD_W'(want.empty), WORD_W'(m_stack_empty));
                    check_field("stopped", WORD_W'(want.stopped), WORD_W'(m_stopped));
                    check_field("error_code", WORD_W'(want.err), WORD_W'(m_error_code));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                pred = machine_step(MIRROR, s_instruction_word);
                awaited_results.insert(awaited_results.size(), pred);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        finale_t finale;
        int      depth;
        int      pick;
        int      random_count;
        logic [WORD_W-1:0] word;

        machine_clear(PLAN);

        // Directed part: immediate extremes, negated zero, wrapping and the divide corners.
        queue_instr({KIND_POS, IMM_MASK}, 1'b0);
        queue_instr({KIND_NEG, IMM_MASK}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_ADD}, 1'b0);
        queue_instr({KIND_NEG, 30'd0}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_SUB}, 1'b0);
        queue_instr({KIND_NEG, 30'h2000_0000}, 1'b0);
        queue_instr({KIND_POS, 30'd4}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_MUL}, 1'b0);
        // The most negative value divided by minus one.
        queue_instr({KIND_NEG, 30'd1}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_DIV}, 1'b0);
        // Subtracting one wraps round to the most positive value.
        queue_instr({KIND_POS, 30'd1}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_SUB}, 1'b0);
        queue_instr({KIND_POS, 30'd3}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_DIV}, 1'b0);
        queue_instr({KIND_NEG, 30'd7}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_DIV}, 1'b0);
        queue_instr({KIND_POS, IMM_MASK}, 1'b0);
        queue_instr({KIND_POS, IMM_MASK}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_MUL}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_SUB}, 1'b0);
        queue_instr({KIND_NEG, 30'd2}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_DIV}, 1'b0);
        queue_instr({KIND_POS, 30'd0}, 1'b0);
        queue_instr({KIND_PRIM, PRIM_ADD}, 1'b0);

        // The stop is chosen first, since filling the stack takes many items of its own.
        finale       = finale_t'($urandom_range(0, 5));
        random_count = (finale == FIN_OVERFLOW) ? RANDOM_ITEMS - STACK_DEPTH : RANDOM_ITEMS;

        // Random part: a well-formed program that never stops the machine.
        for (int i = 0; i < random_count; i++) begin
            depth = shadow_depth[PLAN];
            pick  = $urandom_range(0, 99);
            if (depth < 2 || (depth < 48 && pick < 50)) begin
                word = {pick_push_kind(), pick_imm()};
            end else if (pick < 88 || shadow_mem[PLAN][depth-1] == '0) begin
                word = {KIND_PRIM, IMM_W'($urandom_range(1, 3))};
            end else begin
                word = {KIND_PRIM, PRIM_DIV};
            end
            queue_instr(word, (i == 0) || ($urandom_range(0, 99) == 0));
        end

        // The one stop of the run, chosen at random.
        case (finale)
            FIN_HALT: begin
                queue_instr({KIND_PRIM, PRIM_HALT}, 1'b0);
            end
            FIN_UNDERFLOW: begin
                while (shadow_depth[PLAN] > 1) queue_instr({KIND_PRIM, PRIM_ADD}, 1'b0);
                queue_instr({KIND_PRIM, IMM_W'($urandom_range(1, 4))}, 1'b0);
            end
            FIN_DIVZERO: begin
                queue_instr({pick_push_kind(), 30'd0}, 1'b0);
                queue_instr({KIND_PRIM, PRIM_DIV}, 1'b0);
            end
            FIN_UNKNOWN: begin
                queue_instr({KIND_PRIM, IMM_W'($urandom_range(5, 32'h3fff_ffff))}, 1'b0);
            end
            FIN_BADTYPE: begin
                queue_instr({KIND_BAD, IMM_W'($urandom)}, 1'b0);
            end
            default: begin
                while (shadow_depth[PLAN] < STACK_DEPTH) begin
                    queue_instr({pick_push_kind(), pick_imm()}, 1'b0);
                end
                queue_instr({pick_push_kind(), pick_imm()}, 1'b0);
            end
        endcase

        // Once stopped, every further item must be ignored.
        for (int i = 0; i < NOISE_ITEMS; i++) begin
            queue_instr($urandom, ($urandom_range(0, 3) == 0));
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (instr_q.size() != 0 || s_valid || awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_ITEMS) @(posedge aclk);

        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #8000000;
        $display("timeout with %0d results still awaited", awaited_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
